[design/rot3d_pkg.sv]
// Shared constants, register codes and the series reciprocal tables for the
// 3D point rotation block. No dependencies.
package rot3d_pkg;

  localparam int ANGLE_W      = 17;      // angle register, 1/128 degree
  localparam int FULL_TURN    = 46080;   // 360 degrees
  localparam int QUARTER_TURN = 11520;
  localparam int EIGHTH_TURN  = 5760;
  localparam int T_W          = 13;      // folded angle, at most an eighth turn
  localparam int Q_W          = 31;      // Q30 series values, unsigned
  localparam int ACC_W        = 32;      // series sums
  localparam int STEP_W       = 4;
  localparam int CFG_IDX_W    = 3;

  // x = (t*pi_q30 + QUARTER_TURN) / 23040 is split as t*X_INT plus
  // (t*X_FRAC + QUARTER_TURN) / 23040; the small part is taken as
  // (n >> 9) / 45 by a reciprocal multiply, exact for n >> 9 below 2^18.
  localparam int X_INT        = 146408;
  localparam int X_FRAC       = 19106;
  localparam int XF_W         = 27;
  localparam int X_SH         = 9;
  localparam int XN_W         = 18;
  localparam int XR_W         = 19;
  localparam int X_RECIP      = 372828;
  localparam int X_RSH        = 24;

  localparam int RCP_W        = 32;      // series reciprocal
  localparam int RSH_W        = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_ANGLE_X  = 3'd3,
    REG_ANGLE_Y  = 3'd4,
    REG_ANGLE_Z  = 3'd5
  } cfg_reg_e;

  // Steps 0..3 are sine terms x^3..x^9 (divide by 6, 20, 42, 72),
  // 4..8 cosine terms x^2..x^10 (divide by 2, 12, 30, 56, 90).
  // floor(n/d) = (n * ceil(2^s/d)) >> s for any 31-bit n, s = 31 + ceil(log2 d).
  function automatic logic [RCP_W-1:0] term_recip(input logic [STEP_W-1:0] k);
    logic [RCP_W-1:0] m;
    case (k)
      4'd0:    m = 32'd2863311531;
      4'd1:    m = 32'd3435973837;
      4'd2:    m = 32'd3272356036;
      4'd3:    m = 32'd3817748708;
      4'd4:    m = 32'd2147483648;
      4'd5:    m = 32'd2863311531;
      4'd6:    m = 32'd2290649225;
      4'd7:    m = 32'd2454267027;
      4'd8:    m = 32'd3054198967;
      default: m = 32'd2147483648;
    endcase
    return m;
  endfunction

  function automatic logic [RSH_W-1:0] term_shift(input logic [STEP_W-1:0] k);
    logic [RSH_W-1:0] s;
    case (k)
      4'd0:    s = 6'd34;
      4'd1:    s = 6'd36;
      4'd2:    s = 6'd37;
      4'd3:    s = 6'd38;
      4'd4:    s = 6'd32;
      4'd5:    s = 6'd35;
      4'd6:    s = 6'd36;
      4'd7:    s = 6'd37;
      4'd8:    s = 6'd38;
      default: s = 6'd31;
    endcase
    return s;
  endfunction

endpackage

[design/rot3d_trig.sv]
// Sine/cosine derivation for the three angle registers: range reduction,
// Taylor series in Q30 with a shared multiplier and reciprocal constant divides.
// Depends on rot3d_pkg.
module rot3d_trig #(
  parameter int TRIG_WIDTH = 18
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [2:0]                           angle_wr_i,
  input  logic signed [rot3d_pkg::ANGLE_W-1:0] angle_i [3],
  output logic                                 busy_o,
  output logic signed [TRIG_WIDTH-1:0]         cos_o [3],
  output logic signed [TRIG_WIDTH-1:0]         sin_o [3]
);

  localparam int TRIG_FRAC = TRIG_WIDTH - 2;
  localparam int SH        = 30 - TRIG_FRAC;
  localparam int R_W       = rot3d_pkg::ANGLE_W + 1;
  localparam int XP_W      = rot3d_pkg::XN_W + rot3d_pkg::XR_W;
  localparam int DP_W      = rot3d_pkg::Q_W + rot3d_pkg::RCP_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_REDUCE, ST_QUAD, ST_FOLD, ST_DIVX, ST_XFIN, ST_SQR, ST_MUL, ST_DIV,
    ST_DONE
  } state_e;

  state_e                            state_q;
  logic [2:0]                        pend_q;
  logic [1:0]                        idx_q;
  logic signed [R_W-1:0]             r_q;
  logic [1:0]                        quad_q;
  logic                              fold_q;
  logic [rot3d_pkg::T_W-1:0]         t_q;
  logic [rot3d_pkg::XN_W-1:0]        xn_q;
  logic [rot3d_pkg::Q_W-1:0]         x_q, x2_q, term_q, num_q;
  logic [rot3d_pkg::ACC_W-1:0]       sq_q, cq_q;
  logic [rot3d_pkg::STEP_W-1:0]      k_q;

  logic [1:0]                        pick;
  logic [2:0]                        clr;
  logic [rot3d_pkg::T_W-1:0]         t_fold;
  logic [rot3d_pkg::Q_W-1:0]         x_hi;
  logic [rot3d_pkg::XF_W-1:0]        x_lo;
  logic [XP_W-1:0]                   x_rp;
  logic [rot3d_pkg::Q_W-1:0]         mul_a, mul_b, mul_rnd;
  logic [2*rot3d_pkg::Q_W-1:0]       mul_p;
  logic [DP_W-1:0]                   div_p;
  logic [rot3d_pkg::Q_W-1:0]         div_q;
  logic [rot3d_pkg::ACC_W-1:0]       s_rnd, c_rnd;
  logic signed [TRIG_WIDTH-1:0]      s_mag, c_mag, s1, c1, s_fin, c_fin;

  always_comb begin
    if (pend_q[0]) begin
      pick = 2'd0;
    end else if (pend_q[1]) begin
      pick = 2'd1;
    end else begin
      pick = 2'd2;
    end
    clr = '0;
    if (state_q == ST_IDLE && pend_q != '0) begin
      clr[pick] = 1'b1;
    end
  end

  assign t_fold = (r_q > R_W'(rot3d_pkg::EIGHTH_TURN)) ?
                  rot3d_pkg::T_W'(R_W'(rot3d_pkg::QUARTER_TURN) - r_q) :
                  rot3d_pkg::T_W'(r_q);

  // x = t*X_INT + ((t*X_FRAC + QUARTER_TURN) >> 9) / 45
  assign x_hi = rot3d_pkg::Q_W'(t_q) * rot3d_pkg::Q_W'(rot3d_pkg::X_INT);
  assign x_lo = rot3d_pkg::XF_W'(t_q) * rot3d_pkg::XF_W'(rot3d_pkg::X_FRAC)
              + rot3d_pkg::XF_W'(rot3d_pkg::QUARTER_TURN);
  assign x_rp = XP_W'(xn_q) * XP_W'(rot3d_pkg::X_RECIP);

  // one Q30 multiplier: x*x once, then term*x^2 for each series step
  assign mul_a   = (state_q == ST_SQR) ? x_q : term_q;
  assign mul_b   = (state_q == ST_SQR) ? x_q : x2_q;
  assign mul_p   = mul_a * mul_b + (2*rot3d_pkg::Q_W)'(64'd1 << 29);
  assign mul_rnd = mul_p[30 +: rot3d_pkg::Q_W];

  // series term divide by reciprocal multiply
  assign div_p = DP_W'(num_q) * DP_W'(rot3d_pkg::term_recip(k_q));
  assign div_q = rot3d_pkg::Q_W'(div_p >> rot3d_pkg::term_shift(k_q));

  assign s_rnd = sq_q + (rot3d_pkg::ACC_W'(1) << (SH - 1));
  assign c_rnd = cq_q + (rot3d_pkg::ACC_W'(1) << (SH - 1));
  assign s_mag = TRIG_WIDTH'(s_rnd >> SH);
  assign c_mag = TRIG_WIDTH'(c_rnd >> SH);
  assign s1    = fold_q ? c_mag : s_mag;
  assign c1    = fold_q ? s_mag : c_mag;

  always_comb begin
    case (quad_q)
      2'd0:    begin s_fin = s1;  c_fin = c1;  end
      2'd1:    begin s_fin = c1;  c_fin = -s1; end
      2'd2:    begin s_fin = -s1; c_fin = -c1; end
      default: begin s_fin = -c1; c_fin = s1;  end
    endcase
  end

  assign busy_o = (pend_q != '0) || (state_q != ST_IDLE) || (angle_wr_i != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
      idx_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        cos_o[i] <= TRIG_WIDTH'(1) << TRIG_FRAC;
        sin_o[i] <= '0;
      end
    end else begin
      pend_q <= (pend_q & ~clr) | angle_wr_i;
      case (state_q)
        ST_IDLE: begin
          if (pend_q != '0) begin
            idx_q   <= pick;
            r_q     <= R_W'(angle_i[pick]);
            quad_q  <= '0;
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (r_q < 0) begin
            r_q <= r_q + R_W'(rot3d_pkg::FULL_TURN);
          end else if (r_q >= R_W'(rot3d_pkg::FULL_TURN)) begin
            r_q <= r_q - R_W'(rot3d_pkg::FULL_TURN);
          end else begin
            state_q <= ST_QUAD;
          end
        end
        ST_QUAD: begin
          if (r_q >= R_W'(rot3d_pkg::QUARTER_TURN)) begin
            r_q    <= r_q - R_W'(rot3d_pkg::QUARTER_TURN);
            quad_q <= quad_q + 2'd1;
          end else begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          fold_q  <= r_q > R_W'(rot3d_pkg::EIGHTH_TURN);
          t_q     <= t_fold;
          state_q <= ST_DIVX;
        end
        ST_DIVX: begin
          x_q     <= x_hi;
          xn_q    <= x_lo[rot3d_pkg::XF_W-1:rot3d_pkg::X_SH];
          state_q <= ST_XFIN;
        end
        ST_XFIN: begin
          x_q     <= x_q + rot3d_pkg::Q_W'(x_rp >> rot3d_pkg::X_RSH);
          state_q <= ST_SQR;
        end
        ST_SQR: begin
          x2_q    <= mul_rnd;
          term_q  <= x_q;
          sq_q    <= rot3d_pkg::ACC_W'(x_q);
          cq_q    <= rot3d_pkg::ACC_W'(1) << 30;
          k_q     <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          num_q   <= mul_rnd;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // cosine series restarts at one after the last sine term
          term_q <= (k_q == 4'd3) ? (rot3d_pkg::Q_W'(1) << 30) : div_q;
          // series signs alternate; even steps subtract
          if (k_q < 4'd4) begin
            sq_q <= k_q[0] ? sq_q + rot3d_pkg::ACC_W'(div_q)
                           : sq_q - rot3d_pkg::ACC_W'(div_q);
          end else begin
            cq_q <= k_q[0] ? cq_q + rot3d_pkg::ACC_W'(div_q)
                           : cq_q - rot3d_pkg::ACC_W'(div_q);
          end
          k_q     <= k_q + 1'b1;
          state_q <= (k_q == 4'd8) ? ST_DONE : ST_MUL;
        end
        ST_DONE: begin
          sin_o[idx_q] <= s_fin;
          cos_o[idx_q] <= c_fin;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/rot3d_stage.sv]
// One plane rotation about a center: subtract, multiply, round/add/saturate,
// each in its own register stage. Depends on nothing outside this file.
module rot3d_stage #(
  parameter int COORD_WIDTH = 32,
  parameter int TRIG_WIDTH  = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          skip_i,
  input  logic signed [COORD_WIDTH-1:0] ca_i,
  input  logic signed [COORD_WIDTH-1:0] cb_i,
  input  logic signed [TRIG_WIDTH-1:0]  cos_i,
  input  logic signed [TRIG_WIDTH-1:0]  sin_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] a_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  input  logic signed [COORD_WIDTH-1:0] p_i,
  input  logic                          clip_i,
  input  logic                          last_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] a_o,
  output logic signed [COORD_WIDTH-1:0] b_o,
  output logic signed [COORD_WIDTH-1:0] p_o,
  output logic                          clip_o,
  output logic                          last_o
);

  localparam int TRIG_FRAC = TRIG_WIDTH - 2;
  localparam int D_W       = COORD_WIDTH + 1;
  localparam int M_W       = D_W + TRIG_WIDTH;
  localparam int PW        = COORD_WIDTH + TRIG_WIDTH + 3;
  localparam logic signed [PW-1:0] HALF    = PW'(64'sd1 <<< (TRIG_FRAC - 1));
  localparam logic signed [PW-1:0] SAT_MAX = PW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_MIN = -SAT_MAX - PW'(1);

  logic                          valid1_q, valid2_q;
  logic signed [D_W-1:0]         da_q, db_q;
  logic signed [COORD_WIDTH-1:0] a1_q, b1_q, p1_q, a2_q, b2_q, p2_q;
  logic                          clip1_q, last1_q, clip2_q, last2_q;
  logic signed [M_W-1:0]         m_ac_q, m_bs_q, m_as_q, m_bc_q;

  logic signed [PW-1:0]          sum_a, sum_b, na, nb;
  logic signed [COORD_WIDTH-1:0] sat_a, sat_b;
  logic                          clip_a, clip_b;

  always_comb begin
    sum_a = PW'(m_ac_q) + PW'(m_bs_q) + HALF;
    sum_b = PW'(m_bc_q) - PW'(m_as_q) + HALF;
    na    = (sum_a >>> TRIG_FRAC) + PW'(ca_i);
    nb    = (sum_b >>> TRIG_FRAC) + PW'(cb_i);
    clip_a = 1'b0;
    clip_b = 1'b0;
    if (na > SAT_MAX) begin
      sat_a = COORD_WIDTH'(SAT_MAX); clip_a = 1'b1;
    end else if (na < SAT_MIN) begin
      sat_a = COORD_WIDTH'(SAT_MIN); clip_a = 1'b1;
    end else begin
      sat_a = COORD_WIDTH'(na);
    end
    if (nb > SAT_MAX) begin
      sat_b = COORD_WIDTH'(SAT_MAX); clip_b = 1'b1;
    end else if (nb < SAT_MIN) begin
      sat_b = COORD_WIDTH'(SAT_MIN); clip_b = 1'b1;
    end else begin
      sat_b = COORD_WIDTH'(nb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid_o  <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid_o  <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      da_q    <= D_W'(a_i) - D_W'(ca_i);
      db_q    <= D_W'(b_i) - D_W'(cb_i);
      a1_q    <= a_i;
      b1_q    <= b_i;
      p1_q    <= p_i;
      clip1_q <= clip_i;
      last1_q <= last_i;

      m_ac_q  <= M_W'(da_q) * M_W'(cos_i);
      m_bs_q  <= M_W'(db_q) * M_W'(sin_i);
      m_as_q  <= M_W'(da_q) * M_W'(sin_i);
      m_bc_q  <= M_W'(db_q) * M_W'(cos_i);
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      p2_q    <= p1_q;
      clip2_q <= clip1_q;
      last2_q <= last1_q;

      // a zero angle leaves the pair untouched
      a_o     <= skip_i ? a2_q : sat_a;
      b_o     <= skip_i ? b2_q : sat_b;
      clip_o  <= clip2_q | (!skip_i & (clip_a | clip_b));
      p_o     <= p2_q;
      last_o  <= last2_q;
    end
  end

endmodule

[design/point_rotate_3d_about_center_top.sv]
// Pipeline: three 3-stage plane rotations from input accept to output valid.
// Throughput: one point per cycle; the whole pipeline holds while the output is stalled.
// An angle write starts sine/cosine derivation on a shared multiplier with reciprocal
// constant divides; input is not accepted meanwhile.
// Reset: centers and angles zero, trig entries cos=1 sin=0, pipeline empty.
module point_rotate_3d_about_center_top #(
  parameter int COORD_WIDTH = 32,
  parameter int TRIG_WIDTH  = 18
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [rot3d_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [((COORD_WIDTH > rot3d_pkg::ANGLE_W) ? COORD_WIDTH
                 : rot3d_pkg::ANGLE_W)-1:0]      cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic                                   s_axis_tlast,  // last_point
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // rot_x, rot_y, rot_z
  output logic                                   m_axis_tuser,  // clipped
  output logic                                   m_axis_tlast   // last_out
);

  localparam int CW     = COORD_WIDTH;
  localparam int DATA_W = ((3*COORD_WIDTH+7)/8)*8;

  logic signed [CW-1:0]                 center_x_q, center_y_q, center_z_q;
  logic signed [rot3d_pkg::ANGLE_W-1:0] angle_q [3];
  logic [2:0]                           angle_wr;
  logic                                 busy, adv, in_valid;
  logic signed [TRIG_WIDTH-1:0]         cos_t [3];
  logic signed [TRIG_WIDTH-1:0]         sin_t [3];

  logic                 vx, vy, vz, cx, cy, cz, lx, ly, lz;
  logic signed [CW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;

  always_comb begin
    angle_wr = '0;
    if (cfg_we_i) begin
      case (rot3d_pkg::cfg_reg_e'(cfg_idx_i))
        rot3d_pkg::REG_ANGLE_X: angle_wr[0] = 1'b1;
        rot3d_pkg::REG_ANGLE_Y: angle_wr[1] = 1'b1;
        rot3d_pkg::REG_ANGLE_Z: angle_wr[2] = 1'b1;
        default:                angle_wr    = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      for (int i = 0; i < 3; i++) begin
        angle_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (rot3d_pkg::cfg_reg_e'(cfg_idx_i))
        rot3d_pkg::REG_CENTER_X: center_x_q <= cfg_data_i[CW-1:0];
        rot3d_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i[CW-1:0];
        rot3d_pkg::REG_CENTER_Z: center_z_q <= cfg_data_i[CW-1:0];
        rot3d_pkg::REG_ANGLE_X:  angle_q[0] <= cfg_data_i[rot3d_pkg::ANGLE_W-1:0];
        rot3d_pkg::REG_ANGLE_Y:  angle_q[1] <= cfg_data_i[rot3d_pkg::ANGLE_W-1:0];
        rot3d_pkg::REG_ANGLE_Z:  angle_q[2] <= cfg_data_i[rot3d_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  rot3d_trig #(.TRIG_WIDTH(TRIG_WIDTH)) u_trig (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .angle_wr_i (angle_wr),
    .angle_i    (angle_q),
    .busy_o     (busy),
    .cos_o      (cos_t),
    .sin_o      (sin_t)
  );

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !busy;
  assign in_valid      = s_axis_tvalid && s_axis_tready;

  // about x: pair (y, z)
  rot3d_stage #(.COORD_WIDTH(CW), .TRIG_WIDTH(TRIG_WIDTH)) u_rot_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .skip_i(angle_q[0] == '0),
    .ca_i(center_y_q), .cb_i(center_z_q), .cos_i(cos_t[0]), .sin_i(sin_t[0]),
    .valid_i(in_valid),
    .a_i(s_axis_tdata[CW +: CW]), .b_i(s_axis_tdata[2*CW +: CW]),
    .p_i(s_axis_tdata[0 +: CW]), .clip_i(1'b0), .last_i(s_axis_tlast),
    .valid_o(vx), .a_o(y1), .b_o(z1), .p_o(x1), .clip_o(cx), .last_o(lx)
  );

  // about y: pair (x, z)
  rot3d_stage #(.COORD_WIDTH(CW), .TRIG_WIDTH(TRIG_WIDTH)) u_rot_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .skip_i(angle_q[1] == '0),
    .ca_i(center_x_q), .cb_i(center_z_q), .cos_i(cos_t[1]), .sin_i(sin_t[1]),
    .valid_i(vx), .a_i(x1), .b_i(z1), .p_i(y1), .clip_i(cx), .last_i(lx),
    .valid_o(vy), .a_o(x2), .b_o(z2), .p_o(y2), .clip_o(cy), .last_o(ly)
  );

  // about z: pair (x, y)
  rot3d_stage #(.COORD_WIDTH(CW), .TRIG_WIDTH(TRIG_WIDTH)) u_rot_z (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .skip_i(angle_q[2] == '0),
    .ca_i(center_x_q), .cb_i(center_y_q), .cos_i(cos_t[2]), .sin_i(sin_t[2]),
    .valid_i(vy), .a_i(x2), .b_i(y2), .p_i(z2), .clip_i(cy), .last_i(ly),
    .valid_o(vz), .a_o(x3), .b_o(y3), .p_o(z3), .clip_o(cz), .last_o(lz)
  );

  assign m_axis_tvalid = vz;
  assign m_axis_tdata  = DATA_W'({z3, y3, x3});
  assign m_axis_tuser  = cz;
  assign m_axis_tlast  = lz;

endmodule

[design/rot3d_checker.sv]
// Port-level checks for the 3D point rotation block, bound to the top level.
// Depends on rot3d_pkg and point_rotate_3d_about_center_top.
module rot3d_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_we_i,
  input logic [rot3d_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // pipeline is frozen while the output is stalled
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // angle write blocks input until sine/cosine are ready
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == rot3d_pkg::REG_ANGLE_X || cfg_idx_i == rot3d_pkg::REG_ANGLE_Y
                 || cfg_idx_i == rot3d_pkg::REG_ANGLE_Z) |=> !s_axis_tready)
    else $error("input accepted during trig derivation");

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind point_rotate_3d_about_center_top rot3d_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rot3d_checker (.*);
